>>> hw/rtl/stfg_pkg.sv
// Shared types and constants for the sine tone frame generator.
package stfg_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CH_W     = 3;
    localparam int CNT_W    = 4;
    localparam int MAG_W    = 24;
    localparam int AMP_W    = 31;
    localparam int PROD_W   = MAG_W + AMP_W;
    localparam int PHASE_W  = 32;
    localparam int WSC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [MAG_W-1:0] MAG_FULL    = 24'hFF_FFFF;
    localparam logic [31:0]      PI_HALF_Q30 = 32'd1686629713;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd2;

    // word size codes
    localparam logic [WSC_W-1:0] WS_8  = 2'd0;
    localparam logic [WSC_W-1:0] WS_16 = 2'd1;
    localparam logic [WSC_W-1:0] WS_24 = 2'd2;
    localparam logic [WSC_W-1:0] WS_32 = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [MAG_W-1:0]           mag_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } lane_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [AMP_W-1:0] mag;
    } scaled_t;

endpackage

>>> hw/rtl/stfg_tick_if.sv
// Frame request channel.
interface stfg_tick_if ();
    logic valid;
    logic ready;
    logic frame_tick;

    modport source (output valid, output frame_tick, input ready);
    modport sink (input valid, input frame_tick, output ready);
endinterface

>>> hw/rtl/stfg_word_if.sv
// Sample word channel.
interface stfg_word_if import stfg_pkg::*; ();
    logic              valid;
    logic              ready;
    sample_t           sample;
    logic [CH_W-1:0]   channel_index;
    logic              last_of_frame;

    modport source (output valid, output sample, output channel_index,
                    output last_of_frame, input ready);
    modport sink (input valid, input sample, input channel_index,
                  input last_of_frame, output ready);
endinterface

>>> hw/rtl/sine_tone_frame_generator_unit.sv
// Top level of the sine tone frame generator.
//
// A word on the frames channel (frame_tick = 1) asks for one audio frame: the
// sine of the current phase, scaled to the selected word size, goes out on the
// samples channel once per channel, channel_index counting up and
// last_of_frame on the final word. The phase then advances by phase_step.
// A word with frame_tick = 0 is taken and does nothing; a channel count of
// zero gives no words but still advances the phase.
// Registers are written through cfg_we / cfg_index / cfg_data, while idle;
// the user must keep to this, the block itself does not enforce it.
// The first word of a frame passes through ROM read, multiply, two fold
// stages, queue and output register. One sample word goes out per cycle
// while the receiver is ready; frame words are taken back to back while up
// to 8 frames sit in the pipeline and sample queue. A stalled receiver holds
// the output word; the queue fills and frames.ready drops. Reset clears phase
// and queue and sets the registers to their defaults (zero step, 16-bit words,
// two channels); the sine ROM is constant, so the block is ready out of reset.
module sine_tone_frame_generator_unit import stfg_pkg::*; #(
    parameter int MAX_CHANNELS    = 8,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    stfg_tick_if.sink             frames,
    stfg_word_if.source           samples,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NLimit = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
    localparam int AddrW  = TABLE_ADDR_BITS + 1;

    logic [PHASE_W-1:0] step_reg;
    logic [WSC_W-1:0]   wsc_reg;
    logic [CNT_W-1:0]   chcnt_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [OCC_W-1:0]   credit_reg;
    lane_ctl_t          ctl1_reg;

    logic [CNT_W-1:0]           n_eff;
    logic                       accept;
    logic                       ticked;
    logic                       has_res;
    logic                       pop;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [AddrW-1:0]           rom_addr;
    mag_t                       rom_data;
    scaled_t                    scaled;

    assign n_eff   = (chcnt_reg > CNT_W'(NLimit)) ? CNT_W'(NLimit) : chcnt_reg;
    assign accept  = frames.valid && frames.ready;
    assign ticked  = accept && frames.frame_tick;
    assign has_res = ticked && (n_eff != '0);
    assign frames.ready = (credit_reg < OCC_W'(FIFO_DEPTH));

    assign idx      = phase_reg[29 -: TABLE_ADDR_BITS];
    assign rom_addr = phase_reg[30] ? (AddrW'(1 << TABLE_ADDR_BITS) - {1'b0, idx})
                                    : {1'b0, idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            wsc_reg    <= WS_16;
            chcnt_reg  <= 4'd2;
            phase_reg  <= '0;
            credit_reg <= '0;
            ctl1_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PHASE_STEP: step_reg  <= cfg_data;
                    CFG_WORD_SIZE:  wsc_reg   <= cfg_data[WSC_W-1:0];
                    CFG_CHANNELS:   chcnt_reg <= cfg_data[CNT_W-1:0];
                    default:        ;
                endcase
            end
            if (ticked)
                phase_reg <= phase_reg + step_reg;
            credit_reg     <= credit_reg + OCC_W'(has_res) - OCC_W'(pop);
            ctl1_reg.valid <= has_res;
            ctl1_reg.neg   <= phase_reg[31];
        end
    end

    stfg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk     (clk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    stfg_scale u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ctl         (ctl1_reg),
        .in_mag         (rom_data),
        .word_size_code (wsc_reg),
        .out            (scaled)
    );

    stfg_frame_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (scaled),
        .chan_count (n_eff),
        .pop        (pop),
        .samples    (samples)
    );

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= OCC_W'(FIFO_DEPTH))
        else $error("frame credit beyond queue depth");

    a_inflight_counted: assert property (@(posedge clk) disable iff (!rst_n)
        OCC_W'($countones({ctl1_reg.valid, scaled.valid})) <= credit_reg)
        else $error("frame in flight without credit");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ticked |=> phase_reg == $past(phase_reg) + $past(step_reg))
        else $error("phase did not advance by step");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ticked |=> $stable(phase_reg))
        else $error("phase moved without a frame");

endmodule

>>> hw/rtl/stfg_sine_rom.sv
// Quarter-wave sine magnitude ROM with registered read.
module stfg_sine_rom import stfg_pkg::*; #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                     clk,
    input  logic [TABLE_ADDR_BITS:0] rd_addr,
    output mag_t                     rd_data
);

    localparam int TblLen = (1 << TABLE_ADDR_BITS) + 1;

    mag_t rom_mem [TblLen];

    // Q30 Taylor series through x^15/15!
    function automatic mag_t quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        x = (64'(PI_HALF_Q30) * 64'(k)) >> TABLE_ADDR_BITS;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (64'(sum) * 64'(MAG_FULL) + (64'd1 << 29)) >> 30;
        if (r > 64'(MAG_FULL))
            r = 64'(MAG_FULL);
        return MAG_W'(r);
    endfunction

    initial
    begin
        for (int k = 0; k < TblLen; k++)
            rom_mem[k] = quarter_sine(32'(k));
    end

    mag_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/stfg_scale.sv
// Amplitude scaling: multiply, then divide by 2^24-1 through end-around folding.
module stfg_scale import stfg_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctl_t        in_ctl,
    input  mag_t             in_mag,
    input  logic [WSC_W-1:0] word_size_code,
    output scaled_t          out
);

    logic [AMP_W-1:0]  amp;
    logic              v2_reg, neg2_reg, v3_reg, neg3_reg, v4_reg, neg4_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [AMP_W-1:0]  q1_reg;
    logic [31:0]       r1_reg;
    logic [AMP_W-1:0]  mag_reg;
    logic [AMP_W-1:0]  mag_next;
    logic [7:0]        q2;
    logic [MAG_W:0]    r2;
    logic              q3;
    logic [MAG_W-1:0]  r3;
    logic              q4;

    always_comb
    begin
        unique case (word_size_code)
            WS_8:    amp = 31'h0000_007F;
            WS_16:   amp = 31'h0000_7FFF;
            WS_24:   amp = 31'h007F_FFFF;
            WS_32:   amp = 31'h7FFF_FFFF;
            default: amp = 31'h0000_7FFF;
        endcase
    end

    always_comb
    begin
        q2 = r1_reg[31:24];
        r2 = {1'b0, r1_reg[MAG_W-1:0]} + {17'd0, q2};
        q3 = r2[MAG_W];
        r3 = r2[MAG_W-1:0] + {23'd0, q3};
        q4 = (r3 == MAG_FULL);
        mag_next = q1_reg + {23'd0, q2} + {30'd0, q3} + {30'd0, q4};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_ctl.valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg2_reg <= in_ctl.neg;
        prod_reg <= PROD_W'(in_mag) * PROD_W'(amp);
        neg3_reg <= neg2_reg;
        q1_reg   <= prod_reg[PROD_W-1:MAG_W];
        r1_reg   <= {8'd0, prod_reg[MAG_W-1:0]} + {1'b0, prod_reg[PROD_W-1:MAG_W]};
        neg4_reg <= neg3_reg;
        mag_reg  <= mag_next;
    end

    assign out.valid = v4_reg;
    assign out.neg   = neg4_reg;
    assign out.mag   = mag_reg;

endmodule

>>> hw/rtl/stfg_frame_emit.sv
// Sample queue and per-channel word emitter with output register.
module stfg_frame_emit import stfg_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  scaled_t          in,
    input  logic [CNT_W-1:0] chan_count,
    output logic             pop,
    stfg_word_if.source      samples
);

    sample_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0]  cnt_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              valid_reg;
    sample_t           sample_reg;
    logic [CH_W-1:0]   chan_reg;
    logic              last_reg;
    sample_t           wr_word;
    logic              load;
    logic              last_ch;

    assign wr_word = in.neg ? (SAMPLE_W'(0) - SAMPLE_W'(in.mag)) : SAMPLE_W'(in.mag);
    assign last_ch = ({1'b0, ch_reg} == (chan_count - 4'd1));
    assign load    = (cnt_reg != '0) && (!valid_reg || samples.ready);
    assign pop     = load && last_ch;

    always_ff @(posedge clk)
    begin
        if (in.valid)
            fifo_mem[wr_ptr_reg] <= wr_word;
        if (load)
        begin
            sample_reg <= fifo_mem[rd_ptr_reg];
            chan_reg   <= ch_reg;
            last_reg   <= last_ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            ch_reg     <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (in.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + OCC_W'(in.valid) - OCC_W'(pop);
            if (load)
                ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
            if (load)
                valid_reg <= 1'b1;
            else if (samples.ready)
                valid_reg <= 1'b0;
        end
    end

    assign samples.valid         = valid_reg;
    assign samples.sample        = sample_reg;
    assign samples.channel_index = chan_reg;
    assign samples.last_of_frame = last_reg;

endmodule

>>> tb/sine_tone_frame_generator_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sine tone frame generator, with its own sine predictor.
module sine_tone_frame_generator_unit_test;
    import stfg_pkg::*;

    localparam int TBL_BITS    = 10;
    localparam int CHAN_MAX    = 8;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        sample_t         sample;
        logic [CH_W-1:0] channel_index;
        logic            last_of_frame;
    } tone_word_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stfg_tick_if frames_if ();
    stfg_word_if samples_if ();

    sine_tone_frame_generator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .frames    (frames_if),
        .samples   (samples_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [MAG_W-1:0]   sine_rom [0:(1 << TBL_BITS)];
    logic [PHASE_W-1:0] tone_phase;
    logic [PHASE_W-1:0] step_reg;
    logic [WSC_W-1:0]   wsc_reg;
    logic [CNT_W-1:0]   chan_reg;

    tone_word_t pending_words[$];
    tone_word_t want;

    int  mismatches;
    int  quiet_cycles;
    int  long_hold;
    bit  send_idle;
    bit  recv_idle;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [MAG_W-1:0] quarter_magnitude(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x    = (64'(PI_HALF_Q30) * 64'(k)) >> TBL_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (longint'(sum) * longint'(MAG_FULL) + (64'd1 << 29)) >> 30;
        if (r > longint'(MAG_FULL))
            r = longint'(MAG_FULL);
        return r[MAG_W-1:0];
    endfunction

    function automatic sample_t sine_sample_at(input logic [PHASE_W-1:0] ph);
        logic [1:0]          quad;
        logic [TBL_BITS-1:0] idx;
        longint unsigned     m;
        longint unsigned     amp;
        longint unsigned     mag;
        int                  bits;
        quad = ph[31:30];
        idx  = ph[29 -: TBL_BITS];
        if (quad[0])
            m = 64'(sine_rom[(1 << TBL_BITS) - int'(idx)]);
        else
            m = 64'(sine_rom[idx]);
        bits = 8 * (int'(wsc_reg) + 1);
        amp  = (64'd1 << (bits - 1)) - 64'd1;
        mag  = (m * amp) / longint'(MAG_FULL);
        if (quad[1])
            return -sample_t'(mag[31:0]);
        return sample_t'(mag[31:0]);
    endfunction

    function automatic void predict_frame(input bit tick);
        int         n;
        sample_t    s;
        tone_word_t w;
        if (!tick)
            return;
        n = (chan_reg > CHAN_MAX) ? CHAN_MAX : int'(chan_reg);
        s = sine_sample_at(tone_phase);
        for (int ch = 0; ch < n; ch++)
        begin
            w.sample        = s;
            w.channel_index = ch[CH_W-1:0];
            w.last_of_frame = (ch + 1 == n);
            pending_words.push_back(w);
        end
        tone_phase = tone_phase + step_reg;
    endfunction

    // called and returns at a falling edge
    task automatic send_frame(input bit tick);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            frames_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frames_if.valid      <= 1'b1;
        frames_if.frame_tick <= tick;
        do
            @(posedge clk);
        while (!frames_if.ready);
        predict_frame(tick);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        frames_if.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_PHASE_STEP: step_reg = data;
            CFG_WORD_SIZE:  wsc_reg  = data[WSC_W-1:0];
            CFG_CHANNELS:   chan_reg = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_reset_state();
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
        wait_idle();
    endtask

    task automatic check_quadrant_points();
        write_register(CFG_WORD_SIZE, WS_32);
        write_register(CFG_CHANNELS, 4'd8);
        write_register(CFG_PHASE_STEP, 32'h4000_0000);
        repeat (5) send_frame(1'b1);
        wait_idle();
        write_register(CFG_WORD_SIZE, WS_8);
        write_register(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        repeat (3) send_frame(1'b1);
        wait_idle();
    endtask

    task automatic check_channel_counts();
        write_register(CFG_PHASE_STEP, 32'h0123_4567);
        write_register(CFG_WORD_SIZE, WS_24);
        write_register(CFG_CHANNELS, 4'd0);
        // no words, but the phase still moves on
        send_frame(1'b1);
        send_frame(1'b1);
        wait_idle();
        write_register(CFG_CHANNELS, 4'd1);
        send_frame(1'b1);
        wait_idle();
        write_register(CFG_CHANNELS, 4'd15);
        send_frame(1'b1);
        wait_idle();
        write_register(CFG_WORD_SIZE, WS_16);
        write_register(CFG_CHANNELS, 4'd9);
        send_frame(1'b1);
        wait_idle();
        // spare index must leave everything alone
        write_register(CFG_SPARE, 32'hFFFF_FFFF);
        send_frame(1'b1);
        wait_idle();
    endtask

    task automatic check_back_pressure();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_register(CFG_CHANNELS, 4'd8);
        write_register(CFG_PHASE_STEP, $urandom);
        long_hold = 300;
        repeat (24) send_frame(1'b1);
        wait_idle();
    endtask

    task automatic check_random_frames();
        logic [PHASE_W-1:0] step;
        logic [CNT_W-1:0]   chans;
        for (int blk = 0; blk < 10; blk++)
        begin
            case ($urandom_range(0, 3))
                0: step = $urandom;
                1: step = $urandom_range(0, 32'h003F_FFFF);
                2: step = 32'h0 - $urandom_range(1, 32'h003F_FFFF);
                default: step = $urandom & 32'hFFF0_0000;
            endcase
            case ($urandom_range(0, 9))
                0: chans = 4'd0;
                1: chans = CNT_W'($urandom_range(9, 15));
                default: chans = CNT_W'($urandom_range(1, 8));
            endcase
            write_register(CFG_PHASE_STEP, step);
            write_register(CFG_WORD_SIZE, ($urandom & ~32'h3) | WSC_W'($urandom_range(0, 3)));
            write_register(CFG_CHANNELS, ($urandom & ~32'hF) | chans);
            send_idle = (blk == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            recv_idle = (blk == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (39) send_frame($urandom_range(0, 19) != 0);
            wait_idle();
        end
    endtask

    initial
    begin
        for (int k = 0; k <= (1 << TBL_BITS); k++)
            sine_rom[k] = quarter_magnitude(k);
        tone_phase = '0;
        step_reg   = '0;
        wsc_reg    = WS_16;
        chan_reg   = 4'd2;
        mismatches = 0;
        long_hold  = 0;
        send_idle  = 1'b1;
        recv_idle  = 1'b1;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PHASE_STEP;
        cfg_data   = '0;
        frames_if.valid      = 1'b0;
        frames_if.frame_tick = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        check_reset_state();
        check_quadrant_points();
        check_channel_counts();
        check_back_pressure();
        check_random_frames();

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // sample receiver
    initial
    begin
        int gap;
        samples_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                gap       = long_hold;
                long_hold = 0;
            end
            else
                gap = recv_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                samples_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            samples_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(samples_if.valid && samples_if.ready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && samples_if.valid && samples_if.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: sample %0d, channel %0d",
                       samples_if.sample, samples_if.channel_index);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (samples_if.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, samples_if.sample);
                    mismatches++;
                end
                if (samples_if.channel_index !== want.channel_index)
                begin
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, samples_if.channel_index);
                    mismatches++;
                end
                if (samples_if.last_of_frame !== want.last_of_frame)
                begin
                    $error("last_of_frame: expected %0d, got %0d",
                           want.last_of_frame, samples_if.last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((frames_if.valid && frames_if.ready) ||
                 (samples_if.valid && samples_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
